@@ rtl/occupancy_grid_count_update_core_macros.svh @@
// Assertion macros for the checker file of the occupancy grid core.
`ifndef OCCUPANCY_GRID_COUNT_UPDATE_CORE_MACROS_SVH
`define OCCUPANCY_GRID_COUNT_UPDATE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGCU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OGCU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ogcu_pkg.sv @@
// Shared types and constants of the occupancy grid count update core.
package ogcu_pkg;

    localparam int LOG2_SIDE_DEF = 6;

    localparam int ROW_W  = 6;
    localparam int VAL_W  = 16;
    localparam int PROB_W = 17;
    localparam int CNT_W  = 32;
    localparam int PROD_W = PROB_W + VAL_W;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 17;

    // Shared serial divider: compare-then-shift, one quotient bit per step.
    localparam int DIV_STEPS = 17;
    localparam int QUO_W     = DIV_STEPS;
    localparam int DEN_W     = CNT_W;
    localparam int REM_W     = CNT_W + 1;
    localparam int NUM_W     = 16;

    localparam logic [VAL_W-1:0]  VALUE_MIN_RST     = 16'd1;
    localparam logic [VAL_W-1:0]  VALUE_MAX_RST     = 16'd65535;
    localparam logic [PROB_W-1:0] PROB_MIN_RST      = 17'd655;
    localparam logic [PROB_W-1:0] PROB_MAX_RST      = 17'd64881;
    localparam logic [VAL_W-1:0]  UNKNOWN_VALUE_RST = 16'd0;
    localparam logic [PROB_W-1:0] UNKNOWN_PROB_RST  = 17'd32768;

    typedef enum logic [CFG_AW-1:0] {
        CFG_VALUE_MIN     = 3'd0,
        CFG_VALUE_MAX     = 3'd1,
        CFG_PROB_MIN      = 3'd2,
        CFG_PROB_MAX      = 3'd3,
        CFG_UNKNOWN_VALUE = 3'd4,
        CFG_UNKNOWN_PROB  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic update;
        logic div_step;
        logic map;
        logic div2_load;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic direct;
    } t_dp_status;

endpackage

@@ rtl/occupancy_grid_count_update_core.sv @@
// Top level of the counting-model occupancy grid cell update core.
//
//  Channel   Handshake            Payload
//  input     start, busy          i_cell_row, i_cell_col, i_is_hit
//  result    o_done (one cycle)   o_cell_value, o_hit_total, o_obs_total
//  config    i_cfg_we             i_cfg_addr, i_cfg_data
//
// An item runs one 17-step pass of the shared serial divider when a clamp or the
// unknown test settles the value, and a second when the value is interpolated; no
// new item is taken until its result is shown.
// After reset a clearing pass writes zero counts into all 2**(2*LOG2_SIDE) cells,
// one per cycle, with busy high.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module occupancy_grid_count_update_core
    import ogcu_pkg::*;
#(
    parameter int LOG2_SIDE = LOG2_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [ROW_W-1:0]  i_cell_col,
    input  logic              i_is_hit,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_cell_value,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_obs_total
);

    t_dp_cmd    cmd;
    t_dp_status st;

    ogcu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ogcu_dp #(
        .LOG2_SIDE (LOG2_SIDE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_is_hit     (i_is_hit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_cell_value (o_cell_value),
        .o_hit_total  (o_hit_total),
        .o_obs_total  (o_obs_total)
    );

endmodule

@@ rtl/ogcu_div.sv @@
// Restoring serial divider shared by the probability and the scaling divisions.
module ogcu_div
    import ogcu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [REM_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_rem_nz,
    output logic             o_last
);

    localparam int STEP_CW = $clog2(DIV_STEPS);

    logic [REM_W-1:0]   r_rem, n_rem;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [DEN_W-1:0]   r_den;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic               r_rnz, n_rnz;
    logic [STEP_CW-1:0] r_cnt;

    logic [REM_W:0]   diff;
    logic             ge;
    logic [REM_W-1:0] rsub;

    assign diff = {1'b0, r_rem} - (REM_W + 1)'(r_den);
    assign ge   = !diff[REM_W];
    assign rsub = ge ? diff[REM_W-1:0] : r_rem;

    // The partial remainder stays below the divisor, so its top bit drops out.
    always_comb begin
        n_rem = {rsub[REM_W-2:0], r_num[NUM_W-1]};
        n_num = {r_num[NUM_W-2:0], 1'b0};
        n_quo = {r_quo[QUO_W-2:0], ge};
        n_rnz = |rsub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + STEP_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
            r_rnz <= n_rnz;
        end
    end

    assign o_quo    = r_quo;
    assign o_rem_nz = r_rnz;
    assign o_last   = i_step && (r_cnt == STEP_CW'(DIV_STEPS - 1));

endmodule

@@ rtl/ogcu_dp.sv @@
// Datapath: configuration registers, count memory, probability mapping and divider.
module ogcu_dp
    import ogcu_pkg::*;
#(
    parameter int LOG2_SIDE = LOG2_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_st,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [ROW_W-1:0]  i_cell_col,
    input  logic              i_is_hit,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output logic [VAL_W-1:0]  o_cell_value,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_obs_total
);

    localparam int IDX_W = 2 * LOG2_SIDE;
    localparam int CELLS = 1 << IDX_W;
    localparam int EXT_W = (LOG2_SIDE > ROW_W) ? LOG2_SIDE : ROW_W;
    localparam int ENT_W = 2 * CNT_W;

    logic [VAL_W-1:0]  r_value_min, r_value_max, r_unk_value;
    logic [PROB_W-1:0] r_prob_min, r_prob_max, r_unk_prob;

    logic [ENT_W-1:0] r_mem [CELLS];
    logic [ENT_W-1:0] r_rd;
    logic [IDX_W-1:0] r_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_clr;
    logic [CNT_W-1:0] r_hits, r_obs;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_val;

    logic [EXT_W-1:0] row_x, col_x;
    logic [IDX_W-1:0] rd_idx;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [ENT_W-1:0] mem_wd;

    logic [CNT_W-1:0] hits_rd, obs_rd, upd_hits, upd_obs;
    logic             sat;

    logic [QUO_W-1:0]  quo;
    logic              rem_nz, div_last, div_load;
    logic [REM_W-1:0]  div_rem;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;

    logic              direct, fall;
    logic [VAL_W-1:0]  dval, rng, q16, fin_val;
    logic [PROB_W-1:0] dpos, span;
    logic [PROD_W-1:0] prod;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_min <= VALUE_MIN_RST;
            r_value_max <= VALUE_MAX_RST;
            r_prob_min  <= PROB_MIN_RST;
            r_prob_max  <= PROB_MAX_RST;
            r_unk_value <= UNKNOWN_VALUE_RST;
            r_unk_prob  <= UNKNOWN_PROB_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_VALUE_MIN:     r_value_min <= i_cfg_data[VAL_W-1:0];
                CFG_VALUE_MAX:     r_value_max <= i_cfg_data[VAL_W-1:0];
                CFG_PROB_MIN:      r_prob_min  <= i_cfg_data[PROB_W-1:0];
                CFG_PROB_MAX:      r_prob_max  <= i_cfg_data[PROB_W-1:0];
                CFG_UNKNOWN_VALUE: r_unk_value <= i_cfg_data[VAL_W-1:0];
                CFG_UNKNOWN_PROB:  r_unk_prob  <= i_cfg_data[PROB_W-1:0];
                default: ;
            endcase
        end
    end

    // Row and column wrap to the grid side.
    assign row_x  = EXT_W'(i_cell_row);
    assign col_x  = EXT_W'(i_cell_col);
    assign rd_idx = {row_x[LOG2_SIDE-1:0], col_x[LOG2_SIDE-1:0]};

    // Count memory: one entry holds the hit count above the observation count.
    assign mem_we = i_cmd.clr_wr || i_cmd.update;
    assign mem_wa = i_cmd.clr_wr ? r_clr : r_idx;
    assign mem_wd = i_cmd.clr_wr ? '0 : {upd_hits, upd_obs};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + IDX_W'(1);
        end
    end

    // Saturated observation count freezes both counters.
    assign hits_rd  = r_rd[ENT_W-1:CNT_W];
    assign obs_rd   = r_rd[CNT_W-1:0];
    assign sat      = &obs_rd;
    assign upd_obs  = sat ? obs_rd : obs_rd + CNT_W'(1);
    assign upd_hits = (!sat && r_hit && !(&hits_rd)) ? hits_rd + CNT_W'(1) : hits_rd;

    // Probability mapping: the quotient of the first division is the Q1.16 probability.
    always_comb begin
        direct = 1'b1;
        dval   = r_value_min;
        if (quo == r_unk_prob) begin
            dval = r_unk_value;
        end else if (quo < r_prob_min) begin
            dval = r_value_min;
        end else if (quo > r_prob_max) begin
            dval = r_value_max;
        end else if (r_prob_max == r_prob_min) begin
            dval = r_value_min;
        end else begin
            direct = 1'b0;
        end
    end

    assign fall = r_value_max < r_value_min;
    assign rng  = fall ? r_value_min - r_value_max : r_value_max - r_value_min;
    assign dpos = quo - r_prob_min;
    assign span = r_prob_max - r_prob_min;
    assign prod = PROD_W'(dpos) * PROD_W'(rng);

    // A falling range rounds down by taking the ceiling of the step and subtracting it.
    assign q16     = quo[VAL_W-1:0];
    assign fin_val = fall ? r_value_min - q16 - VAL_W'(rem_nz) : r_value_min + q16;

    assign div_load = i_cmd.update || i_cmd.div2_load;
    assign div_rem  = i_cmd.update ? REM_W'(upd_hits) : REM_W'(r_prod[PROD_W-1:NUM_W]);
    assign div_num  = i_cmd.update ? '0 : r_prod[NUM_W-1:0];
    assign div_den  = i_cmd.update ? upd_obs : DEN_W'(span);

    ogcu_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (div_load),
        .i_step   (i_cmd.div_step),
        .i_rem    (div_rem),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_quo    (quo),
        .o_rem_nz (rem_nz),
        .o_last   (div_last)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= rd_idx;
            r_hit <= i_is_hit;
        end
        if (i_cmd.update) begin
            r_hits <= upd_hits;
            r_obs  <= upd_obs;
        end
        if (i_cmd.map) begin
            r_prod <= prod;
            r_val  <= dval;
        end else if (i_cmd.fin) begin
            r_val  <= fin_val;
        end
    end

    assign o_st.clr_last = &r_clr;
    assign o_st.div_last = div_last;
    assign o_st.direct   = direct;

    assign o_cell_value = r_val;
    assign o_hit_total  = r_hits;
    assign o_obs_total  = r_obs;

endmodule

@@ rtl/ogcu_ctrl.sv @@
// Controller: sequences the clearing pass and the steps of one cell update.
module ogcu_ctrl
    import ogcu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b0_0000_0001,
        S_IDLE  = 9'b0_0000_0010,
        S_READ  = 9'b0_0000_0100,
        S_DIV1  = 9'b0_0000_1000,
        S_MAP   = 9'b0_0001_0000,
        S_MUL   = 9'b0_0010_0000,
        S_DIV2  = 9'b0_0100_0000,
        S_FIN   = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.update = 1'b1;
                n_state      = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = i_st.direct ? S_DONE : S_MUL;
            end
            S_MUL: begin
                o_cmd.div2_load = 1'b1;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

@@ rtl/ogcu_chk.sv @@
// Port-level checker for the occupancy grid core, bound to the top level.
`include "occupancy_grid_count_update_core_macros.svh"

module ogcu_chk
    import ogcu_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic [CNT_W-1:0] o_hit_total,
    input logic [CNT_W-1:0] o_obs_total
);

    // A result only appears while an item is in flight.
    `OGCU_ASSERT_NOW(a_done_busy, o_done, busy, "result strobe outside an item")

    `OGCU_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe longer than one cycle")

    // An accepted item holds the block busy until its result.
    `OGCU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    `OGCU_ASSERT_NEXT(a_done_frees, o_done, !busy, "block stayed busy after its result")

    // Every result follows at least one observation, and hits never pass it.
    `OGCU_ASSERT_NOW(a_counts_sane, o_done,
        (o_obs_total != '0) && (o_hit_total <= o_obs_total), "inconsistent cell counts")

endmodule

bind occupancy_grid_count_update_core ogcu_chk u_ogcu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_hit_total (o_hit_total),
    .o_obs_total (o_obs_total)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the counting-model occupancy grid cell update core.
module tb
    import ogcu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS        = 1 << (2 * LOG2_SIDE_DEF);
    localparam int HOT_CELLS    = 16;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 191;
    localparam int SETTLE_TICKS = 60;

    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] obs_total;
    } t_cell_update;

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    logic [ROW_W-1:0]  i_cell_row = '0;
    logic [ROW_W-1:0]  i_cell_col = '0;
    logic              i_is_hit   = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic              o_done;
    logic [VAL_W-1:0]  o_cell_value;
    logic [CNT_W-1:0]  o_hit_total;
    logic [CNT_W-1:0]  o_obs_total;

    // Mirror of the block's registers and per-cell counters.
    logic [VAL_W-1:0]  cfg_value_min;
    logic [VAL_W-1:0]  cfg_value_max;
    logic [PROB_W-1:0] cfg_prob_min;
    logic [PROB_W-1:0] cfg_prob_max;
    logic [VAL_W-1:0]  cfg_unknown_value;
    logic [PROB_W-1:0] cfg_unknown_prob;
    logic [CNT_W-1:0]  grid_hits [CELLS];
    logic [CNT_W-1:0]  grid_obs  [CELLS];

    t_cell_update      cell_update_q [$];
    logic [ROW_W-1:0]  hot_row [HOT_CELLS];
    logic [ROW_W-1:0]  hot_col [HOT_CELLS];

    int n_errors   = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_settings = 0;

    occupancy_grid_count_update_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_is_hit     (i_is_hit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_cell_value (o_cell_value),
        .o_hit_total  (o_hit_total),
        .o_obs_total  (o_obs_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [VAL_W-1:0] quantize_prob(input logic [PROB_W-1:0] p);
        longint unsigned d;
        longint unsigned span;
        longint unsigned q;
        if (p == cfg_unknown_prob) return cfg_unknown_value;
        if (p < cfg_prob_min) return cfg_value_min;
        if (p > cfg_prob_max) return cfg_value_max;
        if (cfg_prob_max == cfg_prob_min) return cfg_value_min;
        d    = 64'(p) - 64'(cfg_prob_min);
        span = 64'(cfg_prob_max) - 64'(cfg_prob_min);
        if (cfg_value_max >= cfg_value_min) begin
            q = d * (64'(cfg_value_max) - 64'(cfg_value_min)) / span;
            return VAL_W'(64'(cfg_value_min) + q);
        end
        // A falling range still rounds toward minus infinity, so take the ceiling of the step.
        q = (d * (64'(cfg_value_min) - 64'(cfg_value_max)) + span - 64'd1) / span;
        return VAL_W'(64'(cfg_value_min) - q);
    endfunction

    function automatic t_cell_update predict_update(input logic [ROW_W-1:0] row,
                                                    input logic [ROW_W-1:0] col,
                                                    input logic hit);
        logic [2*ROW_W-1:0] idx;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   obs;
        longint unsigned    p;
        t_cell_update       upd;
        idx  = {row, col};
        hits = grid_hits[idx];
        obs  = grid_obs[idx];
        if (obs != '1) begin
            obs++;
            if (hit && hits != '1) hits++;
        end
        grid_hits[idx] = hits;
        grid_obs[idx]  = obs;
        p = (obs == '0) ? 64'd0 : (64'(hits) << 16) / 64'(obs);
        upd.cell_value = quantize_prob(PROB_W'(p));
        upd.hit_total  = hits;
        upd.obs_total  = obs;
        return upd;
    endfunction

    task automatic reset_grid_model();
        cfg_value_min     = VALUE_MIN_RST;
        cfg_value_max     = VALUE_MAX_RST;
        cfg_prob_min      = PROB_MIN_RST;
        cfg_prob_max      = PROB_MAX_RST;
        cfg_unknown_value = UNKNOWN_VALUE_RST;
        cfg_unknown_prob  = UNKNOWN_PROB_RST;
        for (int i = 0; i < CELLS; i++) begin
            grid_hits[i] = '0;
            grid_obs[i]  = '0;
        end
    endtask

    // Writes all six registers on consecutive edges; the block must be idle.
    task automatic load_settings(input logic [VAL_W-1:0] vmin, input logic [VAL_W-1:0] vmax,
                                 input logic [PROB_W-1:0] pmin, input logic [PROB_W-1:0] pmax,
                                 input logic [VAL_W-1:0] uval, input logic [PROB_W-1:0] uprob);
        logic [CFG_DW-1:0] vals [6];
        t_cfg_idx          reg_idx = CFG_VALUE_MIN;
        vals[CFG_VALUE_MIN]     = CFG_DW'(vmin);
        vals[CFG_VALUE_MAX]     = CFG_DW'(vmax);
        vals[CFG_PROB_MIN]      = CFG_DW'(pmin);
        vals[CFG_PROB_MAX]      = CFG_DW'(pmax);
        vals[CFG_UNKNOWN_VALUE] = CFG_DW'(uval);
        vals[CFG_UNKNOWN_PROB]  = CFG_DW'(uprob);
        reg_idx = reg_idx.first();
        repeat (reg_idx.num()) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= reg_idx;
            i_cfg_data <= vals[reg_idx];
            @(posedge i_clk);
            case (reg_idx)
                CFG_VALUE_MIN:     cfg_value_min     = vals[reg_idx][VAL_W-1:0];
                CFG_VALUE_MAX:     cfg_value_max     = vals[reg_idx][VAL_W-1:0];
                CFG_PROB_MIN:      cfg_prob_min      = vals[reg_idx][PROB_W-1:0];
                CFG_PROB_MAX:      cfg_prob_max      = vals[reg_idx][PROB_W-1:0];
                CFG_UNKNOWN_VALUE: cfg_unknown_value = vals[reg_idx][VAL_W-1:0];
                CFG_UNKNOWN_PROB:  cfg_unknown_prob  = vals[reg_idx][PROB_W-1:0];
                default: ;
            endcase
            reg_idx = reg_idx.next();
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_observation(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col,
                                    input logic hit, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cell_row <= row;
        i_cell_col <= col;
        i_is_hit   <= hit;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cell_update_q.push_back(predict_update(row, col, hit));
        n_items++;
    endtask

    task automatic wait_grid_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (cell_update_q.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int pick_gap(input bit no_idle);
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99, 0);
        if (r < 45) return 0;
        if (r < 75) return $urandom_range(3, 1);
        if (r < 92) return $urandom_range(45, 4);
        return $urandom_range(150, 46);
    endfunction

    // Favors probabilities that the counters actually produce, so clamps and the
    // unknown test land exactly on observed values now and then.
    function automatic logic [PROB_W-1:0] pick_prob();
        if ($urandom_range(99, 0) < 40) begin
            case ($urandom_range(6, 0))
                0:       return 17'd0;
                1:       return 17'd65536;
                2:       return 17'd32768;
                3:       return 17'd21845;
                4:       return 17'd43690;
                5:       return 17'd16384;
                default: return 17'd49152;
            endcase
        end
        return PROB_W'($urandom_range(65536, 0));
    endfunction

    task automatic test_default_mapping();
        send_observation(6'd0,  6'd0,  1'b0, 0);   // all misses, below the lower clamp
        send_observation(6'd63, 6'd63, 1'b1, 0);   // all hits, above the upper clamp
        send_observation(6'd0,  6'd63, 1'b1, 2);
        send_observation(6'd0,  6'd63, 1'b0, 0);   // half hits maps to unknown
        send_observation(6'd63, 6'd0,  1'b1, 0);
        send_observation(6'd63, 6'd0,  1'b1, 30);
        send_observation(6'd63, 6'd0,  1'b0, 0);   // two thirds, interpolated
    endtask

    task automatic test_equal_clamps();
        wait_grid_idle();
        load_settings(16'd100, 16'd200, 17'd32768, 17'd32768, 16'd7, 17'd65536);
        send_observation(6'd1, 6'd1, 1'b1, 0);
        send_observation(6'd1, 6'd1, 1'b0, 0);
        send_observation(6'd1, 6'd2, 1'b0, 0);
        send_observation(6'd1, 6'd1, 1'b1, 0);
    endtask

    task automatic test_crossed_clamps();
        wait_grid_idle();
        load_settings(16'hFFFF, 16'h0000, 17'd40000, 17'd20000, 16'h5555, 17'd0);
        send_observation(6'd2, 6'd2, 1'b0, 0);
        send_observation(6'd2, 6'd2, 1'b1, 0);
        send_observation(6'd2, 6'd3, 1'b1, 0);
    endtask

    task automatic test_falling_range();
        wait_grid_idle();
        load_settings(16'd60000, 16'd100, 17'd0, 17'd65536, 16'hFFFF, 17'd65535);
        send_observation(6'd3, 6'd3, 1'b0, 0);
        send_observation(6'd3, 6'd3, 1'b0, 0);
        send_observation(6'd3, 6'd3, 1'b1, 0);
        send_observation(6'd3, 6'd4, 1'b1, 0);
        send_observation(6'd3, 6'd3, 1'b1, 5);
    endtask

    task automatic test_full_span();
        wait_grid_idle();
        load_settings(16'd0, 16'd65535, 17'd0, 17'd65536, 16'hAAAA, 17'd1);
        send_observation(6'd4, 6'd4, 1'b0, 0);
        send_observation(6'd4, 6'd5, 1'b1, 0);
        send_observation(6'd4, 6'd4, 1'b1, 0);
    endtask

    task automatic test_random_settings();
        int                kind;
        int                hit_pct;
        int                k;
        bit                no_idle;
        logic [VAL_W-1:0]  vmin;
        logic [VAL_W-1:0]  vmax;
        logic [PROB_W-1:0] pmin;
        logic [PROB_W-1:0] pmax;
        logic [PROB_W-1:0] lo;
        logic [PROB_W-1:0] hi;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        // A small set of cells takes most items so that their counts grow and the
        // probability moves through many values.
        for (int i = 0; i < HOT_CELLS; i++) begin
            hot_row[i] = ROW_W'($urandom_range(63, 0));
            hot_col[i] = ROW_W'($urandom_range(63, 0));
        end
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            kind = (phase < 6) ? phase : $urandom_range(5, 1);
            vmin = VAL_W'($urandom_range(65535, 0));
            vmax = VAL_W'($urandom_range(65535, 0));
            lo   = pick_prob();
            hi   = pick_prob();
            if (lo > hi) begin
                pmin = hi;
                hi   = lo;
                lo   = pmin;
            end
            case (kind)
                0: begin
                    vmin = VALUE_MIN_RST;
                    vmax = VALUE_MAX_RST;
                    pmin = PROB_MIN_RST;
                    pmax = PROB_MAX_RST;
                end
                1: begin
                    pmin = pick_prob();
                    pmax = pick_prob();
                end
                2: begin
                    pmin = lo;
                    pmax = lo;
                end
                3: begin
                    if (lo == hi) begin
                        if (hi < 17'd65536) hi++;
                        else lo--;
                    end
                    pmin = hi;
                    pmax = lo;
                end
                4: begin
                    vmin = VAL_W'($urandom_range(65535, 32768));
                    vmax = VAL_W'($urandom_range(32'(vmin) - 32'd1, 0));
                    pmin = lo;
                    pmax = hi;
                end
                default: begin
                    vmin = $urandom_range(1, 0) ? 16'd0 : 16'd65535;
                    vmax = ~vmin;
                    pmin = 17'd0;
                    pmax = 17'd65536;
                end
            endcase
            wait_grid_idle();
            load_settings(vmin, vmax, pmin, pmax, VAL_W'($urandom_range(65535, 0)),
                          pick_prob());
            hit_pct = $urandom_range(100, 0);
            no_idle = ($urandom_range(3, 0) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99, 0) < 70) begin
                    k   = $urandom_range(HOT_CELLS - 1, 0);
                    row = hot_row[k];
                    col = hot_col[k];
                end else begin
                    row = ROW_W'($urandom_range(63, 0));
                    col = ROW_W'($urandom_range(63, 0));
                end
                send_observation(row, col, ($urandom_range(99, 0) < hit_pct), pick_gap(no_idle));
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_cell_update exp_upd;
        if (i_rst_n && o_done) begin
            if (cell_update_q.size() == 0) begin
                $error("unexpected result: cell_value %0d hit_total %0d obs_total %0d",
                       o_cell_value, o_hit_total, o_obs_total);
                n_errors++;
            end else begin
                exp_upd = cell_update_q.pop_front();
                n_checked++;
                if (o_cell_value !== exp_upd.cell_value) begin
                    $error("cell_value: expected %0d, actual %0d",
                           exp_upd.cell_value, o_cell_value);
                    n_errors++;
                end
                if (o_hit_total !== exp_upd.hit_total) begin
                    $error("hit_total: expected %0d, actual %0d",
                           exp_upd.hit_total, o_hit_total);
                    n_errors++;
                end
                if (o_obs_total !== exp_upd.obs_total) begin
                    $error("obs_total: expected %0d, actual %0d",
                           exp_upd.obs_total, o_obs_total);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        reset_grid_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its counters after reset with busy high.
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        test_default_mapping();
        test_equal_clamps();
        test_crossed_clamps();
        test_falling_range();
        test_full_span();
        test_random_settings();

        wait_grid_idle();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        $display("Sent %0d observations under %0d register settings; %0d cell updates checked.",
                 n_items, n_settings, n_checked);
        $display("Settings covered defaults, equal, crossed and full-span clamps, falling ranges.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
